// ===== sv/rtti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtti_pkg
// Shared types and constants of the radix text to integer core.
// ----------------------------------------------------------------------------
package rtti_pkg;

  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int CH_W    = 8;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 4;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] radix;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } cls_t;

endpackage
`default_nettype wire

// ===== sv/radix_text_to_integer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radix_text_to_integer_core
// Converts a character stream to a signed integer in a given or detected base.
// ----------------------------------------------------------------------------
// Input channel: one character word per push, accepted when push is high and
// full is low. start_req marks the first character of a string and radix is
// sampled with it (0 selects the base from the prefix).
// Result channel: a word holding value and end_offset is shown while empty is
// low and is taken when pop is high.
// Throughput is one character per cycle while the result queue has room,
// set by the single multiply-add step of the back end. The ending character
// is registered in the middle queue, and its result in the output queue.
// Characters wait in a two-word queue between the classifier and the parser,
// and results in a two-word queue at the output. When the receiver stalls,
// the output queue fills, the parser holds, and full rises once the middle
// queue is full.
// Reset empties both queues and leaves the parser idle, waiting for a start.
// ----------------------------------------------------------------------------
module radix_text_to_integer_core #(
  parameter int VALUE_WIDTH  = rtti_pkg::VALUE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = rtti_pkg::OFFSET_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = rtti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rtti_pkg::CH_W-1:0]     ch,
  input  logic                          start_req,
  input  logic [rtti_pkg::RADIX_W-1:0]  radix,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic [OFFSET_WIDTH-1:0]       end_offset
);
  import rtti_pkg::*;

  localparam int RES_W = VALUE_WIDTH + OFFSET_WIDTH;

  cls_t                    item_in, item_out;
  logic                    q_push, q_full, q_empty, q_pop;
  logic                    res_push, res_full;
  logic [VALUE_WIDTH-1:0]  res_value;
  logic [OFFSET_WIDTH-1:0] res_offset;
  logic [RES_W-1:0]        res_word;

  assign full = q_full;

  rtti_front u_front (
    .push      (push),
    .ch        (ch),
    .start_req (start_req),
    .radix     (radix),
    .q_full    (q_full),
    .q_push    (q_push),
    .item      (item_in)
  );

  rtti_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (item_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (item_out),
    .empty (q_empty)
  );

  rtti_back #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item_out),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_value  (res_value),
    .res_offset (res_offset)
  );

  rtti_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   ({res_value, res_offset}),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_word),
    .empty (empty)
  );

  assign value      = res_word[RES_W-1:OFFSET_WIDTH];
  assign end_offset = res_word[OFFSET_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== sv/rtti_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtti_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module rtti_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on a lone push");

endmodule
`default_nettype wire

// ===== sv/rtti_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtti_front
// Accepts input words and classifies each character for the back end.
// ----------------------------------------------------------------------------
module rtti_front (
  input  logic                         push,
  input  logic [rtti_pkg::CH_W-1:0]    ch,
  input  logic                         start_req,
  input  logic [rtti_pkg::RADIX_W-1:0] radix,
  input  logic                         q_full,
  output logic                         q_push,
  output rtti_pkg::cls_t               item
);
  import rtti_pkg::*;

  logic dec, low_hex, up_hex;

  assign q_push  = push && !q_full;
  assign dec     = (ch >= CH_0) && (ch <= CH_9);
  assign low_hex = (ch >= CH_LA) && (ch <= CH_LF);
  assign up_hex  = (ch >= CH_UA) && (ch <= CH_UF);

  always_comb begin
    item.start    = start_req;
    item.radix    = radix;
    item.is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) || (ch == CH_CR);
    item.is_plus  = (ch == CH_PLUS);
    item.is_minus = (ch == CH_MINUS);
    item.is_zero  = (ch == CH_0);
    item.is_x     = (ch == CH_LX) || (ch == CH_UX);
    item.is_digit = (dec || low_hex || up_hex) && (ch != CH_NUL);
    if (dec) begin
      item.digit = DIGIT_W'(ch - CH_0);
    end else if (low_hex) begin
      item.digit = DIGIT_W'(ch - CH_LA + 8'd10);
    end else if (up_hex) begin
      item.digit = DIGIT_W'(ch - CH_UA + 8'd10);
    end else begin
      item.digit = '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtti_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtti_back
// Parsing state machine: sign, prefix and base handling, and accumulation.
// ----------------------------------------------------------------------------
module rtti_back #(
  parameter int VALUE_WIDTH  = 32,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rtti_pkg::cls_t          item,
  input  logic                    item_valid,
  output logic                    item_pop,
  input  logic                    res_full,
  output logic                    res_push,
  output logic [VALUE_WIDTH-1:0]  res_value,
  output logic [OFFSET_WIDTH-1:0] res_offset
);
  import rtti_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  logic [2:0]                phase, phase_cur, phase_next;
  logic                      negative, negative_cur, negative_next;
  logic [RADIX_W-1:0]        working_base, base_cur, base_next, take_base;
  logic [VALUE_WIDTH-1:0]    accumulator, acc_cur, acc_next;
  logic [OFFSET_WIDTH-1:0]   position, pos_cur, pos_next, pos_inc;
  logic [VALUE_WIDTH+RADIX_W-1:0] prod;
  logic                      prefix_path, take, stop, emit;

  assign item_pop     = item_valid && !res_full;
  assign phase_cur    = item.start ? PH_LEAD : phase;
  assign negative_cur = item.start ? 1'b0 : negative;
  assign base_cur     = item.start ? item.radix : working_base;
  assign acc_cur      = item.start ? '0 : accumulator;
  assign pos_cur      = item.start ? '0 : position;
  assign pos_inc      = (pos_cur == '1) ? pos_cur : pos_cur + 1'b1;
  assign res_value    = negative_cur ? ('0 - acc_cur) : acc_cur;
  assign res_offset   = pos_cur;
  assign res_push     = item_pop && emit;

  always_comb begin
    phase_next    = phase_cur;
    negative_next = negative_cur;
    base_next     = base_cur;
    acc_next      = acc_cur;
    pos_next      = pos_cur;
    prefix_path   = 1'b0;
    take          = 1'b0;
    take_base     = base_cur;
    emit          = 1'b0;
    unique case (phase_cur)
      PH_LEAD: begin
        if (item.is_space) begin
          pos_next = pos_inc;
        end else if (item.is_plus || item.is_minus) begin
          negative_next = item.is_minus;
          pos_next      = pos_inc;
          phase_next    = PH_PREFIX;
        end else begin
          prefix_path = 1'b1;
        end
      end
      PH_PREFIX: begin
        prefix_path = 1'b1;
      end
      PH_ZERO: begin
        if (item.is_x) begin
          base_next  = BASE_HEX;
          pos_next   = pos_inc;
          phase_next = PH_DIGITS;
        end else begin
          take      = 1'b1;
          take_base = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (prefix_path) begin
      if (item.is_zero && (base_cur == BASE_AUTO || base_cur == BASE_HEX)) begin
        pos_next   = pos_inc;
        phase_next = PH_ZERO;
      end else begin
        take      = 1'b1;
        take_base = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
      end
    end
    stop = !item.is_digit || (RADIX_W'(item.digit) >= take_base);
    prod = acc_cur * take_base;
    if (take) begin
      base_next = take_base;
      if (stop) begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        acc_next   = VALUE_WIDTH'(prod + (VALUE_WIDTH + RADIX_W)'(item.digit));
        pos_next   = pos_inc;
        phase_next = PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      negative     <= 1'b0;
      working_base <= '0;
      accumulator  <= '0;
      position     <= '0;
    end else if (item_pop) begin
      phase        <= phase_next;
      negative     <= negative_next;
      working_base <= base_next;
      accumulator  <= acc_next;
      position     <= pos_next;
    end
  end

  a_push_needs_item: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (item_valid && !res_full))
    else $error("result word pushed without a consumed item");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (phase == PH_IDLE))
    else $error("parser not idle after a result word");

endmodule
`default_nettype wire

// ===== test/radix_text_to_integer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_to_integer_checker
// Watches both channels of the radix text to integer core. It parses every
// accepted character word with its own model of the core and queues the
// expected results. Each popped result word is compared field by field with
// the oldest expected one, and the mismatches are counted for the top.
// ----------------------------------------------------------------------------
module radix_text_to_integer_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [rtti_pkg::CH_W-1:0]    ch,
  input  logic                         start_req,
  input  logic [rtti_pkg::RADIX_W-1:0] radix,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [31:0]           value,
  input  logic [15:0]                  end_offset,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import rtti_pkg::*;

  localparam logic [4:0] NOT_DIGIT = 5'd16;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_SIGNED,
    ST_ZERO,
    ST_DIGITS
  } parse_phase_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] end_offset;
  } parse_result_t;

  parse_phase_t        phase;
  logic                negative;
  logic [RADIX_W-1:0]  base;
  logic [31:0]         acc;
  logic [15:0]         pos;
  parse_result_t       parsed_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic [4:0] digit_val(input logic [CH_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) begin
      return 5'(c - CH_0);
    end
    if (c >= CH_LA && c <= CH_LF) begin
      return 5'(c - CH_LA + 8'd10);
    end
    if (c >= CH_UA && c <= CH_UF) begin
      return 5'(c - CH_UA + 8'd10);
    end
    return NOT_DIGIT;
  endfunction

  task automatic bump_pos();
    if (pos < POS_MAX) begin
      pos = pos + 16'd1;
    end
  endtask

  task automatic take_digit(input logic [CH_W-1:0] c);
    logic [4:0]    d;
    parse_result_t r;
    d = digit_val(c);
    if (c == CH_NUL || d == NOT_DIGIT || {1'b0, d} >= base) begin
      r.value      = negative ? (32'd0 - acc) : acc;
      r.end_offset = pos;
      parsed_q.push_back(r);
      phase = ST_IDLE;
    end else begin
      acc = acc * 32'(base) + 32'(d);
      bump_pos();
      phase = ST_DIGITS;
    end
  endtask

  task automatic first_char(input logic [CH_W-1:0] c);
    if (c == CH_0 && (base == BASE_AUTO || base == BASE_HEX)) begin
      bump_pos();
      phase = ST_ZERO;
    end else begin
      if (base == BASE_AUTO) begin
        base = BASE_DEC;
      end
      take_digit(c);
    end
  endtask

  task automatic parse_char(input logic [CH_W-1:0] c, input logic s,
                            input logic [RADIX_W-1:0] r);
    if (s) begin
      phase    = ST_LEAD;
      negative = 1'b0;
      base     = r;
      acc      = '0;
      pos      = '0;
    end
    case (phase)
      ST_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR) begin
          bump_pos();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          negative = (c == CH_MINUS);
          bump_pos();
          phase = ST_SIGNED;
        end else begin
          first_char(c);
        end
      end
      ST_SIGNED: begin
        first_char(c);
      end
      ST_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          base = BASE_HEX;
          bump_pos();
          phase = ST_DIGITS;
        end else begin
          if (base == BASE_AUTO) begin
            base = BASE_OCT;
          end
          take_digit(c);
        end
      end
      ST_DIGITS: begin
        take_digit(c);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      phase    = ST_IDLE;
      negative = 1'b0;
      base     = '0;
      acc      = '0;
      pos      = '0;
      parsed_q.delete();
    end else begin
      if (pop && !empty) begin
        if (parsed_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("%t: unexpected result word value=%0d end_offset=%0d", $realtime,
                     value, end_offset);
          end
        end else begin
          want = parsed_q.pop_front();
          checked = checked + 1;
          if (value !== want.value || end_offset !== want.end_offset) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("%t: result mismatch: value %0d (expected %0d), end_offset %0d (expected %0d)",
                       $realtime, value, $signed(want.value), end_offset, want.end_offset);
            end
          end
        end
      end
      if (push && !full) begin
        parse_char(ch, start_req, radix);
      end
    end
    pending = parsed_q.size();
  end

endmodule

// ===== test/radix_text_to_integer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_to_integer_core_tb
// Drives character strings into the radix text to integer core and gives the
// verdict. Directed strings cover whitespace, signs, prefixes, base detection,
// bases 1, 2 and 36, restarts and ignored words; random strings follow, then a
// long receiver hold-off while short strings keep arriving.
// Both sides idle at random outside the quiet stretches; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module radix_text_to_integer_core_tb;
  import rtti_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 620;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [CH_W-1:0]     ch = '0;
  logic                start_req = 1'b0;
  logic [RADIX_W-1:0]  radix = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic signed [31:0]  value;
  logic [15:0]         end_offset;

  int errors;
  int pending;
  int checked;
  int cycles = 0;
  int strings_sent = 0;
  int words_sent = 0;
  bit quiet = 1'b0;
  bit hold_pop = 1'b0;

  radix_text_to_integer_core uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .ch         (ch),
    .start_req  (start_req),
    .radix      (radix),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .end_offset (end_offset)
  );

  radix_text_to_integer_checker chk (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .ch         (ch),
    .start_req  (start_req),
    .radix      (radix),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .end_offset (end_offset),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
    $display("radix_text_to_integer_core_tb: errors");
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_pop && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        pop <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_word(input logic [CH_W-1:0] c, input logic s,
                           input logic [RADIX_W-1:0] r);
    while (!quiet && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    ch        <= c;
    start_req <= s;
    radix     <= r;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic send_bytes(input logic [CH_W-1:0] txt[$], input logic [RADIX_W-1:0] r);
    for (int i = 0; i < txt.size(); i++) begin
      send_word(txt[i], i == 0, r);
    end
    strings_sent++;
  endtask

  task automatic send_string(input string s, input logic [RADIX_W-1:0] r, input int term);
    logic [CH_W-1:0] txt[$];
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s[i]);
    end
    if (term >= 0) begin
      txt.push_back(term[7:0]);
    end
    send_bytes(txt, r);
  endtask

  task automatic send_random_string(output int n);
    logic [CH_W-1:0]    txt[$];
    logic [RADIX_W-1:0] r;
    int                 eff;
    int                 nd;
    int                 maxd;
    int                 d;
    int                 pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: r = BASE_AUTO;
      3:       r = 6'd2;
      4:       r = BASE_OCT;
      5:       r = BASE_DEC;
      6:       r = BASE_HEX;
      default: r = 6'($urandom_range(36));
    endcase
    if ($urandom_range(99) < 15) begin
      nd = $urandom_range(1, 6);
      for (int i = 0; i < nd; i++) begin
        txt.push_back(8'($urandom_range(255)));
      end
    end else begin
      nd = $urandom_range(2);
      for (int i = 0; i < nd; i++) begin
        case ($urandom_range(3))
          0:       txt.push_back(CH_SPACE);
          1:       txt.push_back(CH_TAB);
          2:       txt.push_back(CH_NL);
          default: txt.push_back(CH_CR);
        endcase
      end
      case ($urandom_range(2))
        1:       txt.push_back(CH_PLUS);
        2:       txt.push_back(CH_MINUS);
        default: ;
      endcase
      eff = r;
      if (r == BASE_AUTO) begin
        case ($urandom_range(2))
          0: eff = 10;
          1: begin
            txt.push_back(CH_0);
            txt.push_back($urandom_range(1) ? CH_LX : CH_UX);
            eff = 16;
          end
          default: begin
            txt.push_back(CH_0);
            eff = 8;
          end
        endcase
      end else if (r == BASE_HEX && $urandom_range(1)) begin
        txt.push_back(CH_0);
        txt.push_back($urandom_range(1) ? CH_LX : CH_UX);
      end
      maxd = (eff > 16) ? 16 : eff;
      nd = (eff <= 1 || $urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < nd; i++) begin
        d = $urandom_range(maxd - 1);
        if (d < 10) begin
          txt.push_back(8'(CH_0 + d));
        end else begin
          txt.push_back(8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10));
        end
      end
      case ($urandom_range(3))
        1: txt.push_back(8'($urandom_range(255)));
        2: begin
          if (eff < 10) begin
            txt.push_back(8'(CH_0 + eff));
          end else if (eff < 16) begin
            txt.push_back(8'(CH_LA + eff - 10));
          end else begin
            txt.push_back(8'h67);
          end
        end
        default: txt.push_back(CH_NUL);
      endcase
    end
    send_bytes(txt, r);
    n = txt.size();
    if ($urandom_range(9) == 0) begin
      send_word(8'($urandom_range(255)), 1'b0, 6'($urandom_range(36)));
    end
  endtask

  initial begin
    logic [CH_W-1:0] txt[$];
    int              items;
    int              n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(8'h71, 1'b0, BASE_HEX);
    send_string("\t+0779", BASE_AUTO, -1);
    send_string(" -0x1f", BASE_AUTO, CH_NUL);
    send_string("-0Xg", BASE_HEX, -1);
    send_string("5", 6'd1, -1);
    send_string("\nfF", 6'd36, CH_NUL);
    send_string("\r1012", 6'd2, -1);
    send_string("12", BASE_DEC, -1);
    send_string("3", BASE_DEC, CH_NUL);
    send_word(8'h37, 1'b0, BASE_DEC);
    send_string("8", BASE_DEC, 255);
    send_string("0", BASE_AUTO, CH_NUL);
    send_string("+", BASE_DEC, 8'h2F);
    send_string("0XA", BASE_AUTO, CH_NUL);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      quiet = (items >= 250 && items < 450);
      send_random_string(n);
      items += n;
    end
    quiet = 1'b0;

    quiet = 1'b1;
    hold_pop = 1'b1;
    for (int k = 0; k < 40; k++) begin
      txt.delete();
      txt.push_back(8'(CH_0 + k % 10));
      txt.push_back(CH_NUL);
      send_bytes(txt, BASE_DEC);
    end
    quiet = 1'b0;

    push <= 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d strings in %0d character words and checked %0d results,",
             strings_sent, words_sent, checked);
    $display("across detected and fixed bases, restarts, ignored words and a hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("radix_text_to_integer_core_tb: clean");
    end else begin
      $display("radix_text_to_integer_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== radix_text_to_integer_core.f =====
sv/rtti_pkg.sv
sv/rtti_fifo.sv
sv/rtti_front.sv
sv/rtti_back.sv
sv/radix_text_to_integer_core.sv
test/radix_text_to_integer_checker.sv
test/radix_text_to_integer_core_tb.sv
